// File: sv/hcbf_pkg.sv
`timescale 1ns / 1ps

package hcbf_pkg;

    // Field widths
    localparam int unsigned LAYER_W = 5;
    localparam int unsigned NIDX_W  = 14;
    localparam int unsigned MAG_W   = 16;
    localparam int unsigned ACT_W   = 24;
    localparam int unsigned BATCH_W = 16;
    localparam int unsigned CNT_W   = 40;
    localparam int unsigned HOTB_W  = 11;
    localparam int unsigned GAIN_W  = 34;   // 655 * (mag << 8) fits in 34 bits
    localparam int unsigned SUM_W   = 41;   // decay product plus gain term

    // Q16 filter coefficients (0.99 and 0.01)
    localparam logic [15:0] DECAY_Q16 = 16'd64881;
    localparam logic [9:0]  GAIN_Q16  = 10'd655;

    localparam logic [ACT_W-1:0]   ACT_MAX   = '1;
    localparam logic [BATCH_W-1:0] BATCH_MAX = '1;
    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
    localparam logic [HOTB_W-1:0]  HOTB_RESET = 11'd1024;

    // Configuration register indexes
    localparam logic [1:0] CFG_TIER_ENABLED   = 2'd0;
    localparam logic [1:0] CFG_HOT_BUNDLES    = 2'd1;
    localparam logic [1:0] CFG_COLD_THRESHOLD = 2'd2;

    typedef enum logic [1:0] {
        OUT_HOT_HIT    = 2'd0,
        OUT_COLD_FETCH = 2'd1,
        OUT_COLD_DROP  = 2'd2
    } t_outcome;

    function automatic logic [CNT_W-1:0] inc_cnt(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [BATCH_W-1:0] inc_batch(input logic [BATCH_W-1:0] v);
        return (v == BATCH_MAX) ? v : v + BATCH_W'(1);
    endfunction

endpackage

// File: sv/hcbf_ram.sv
`timescale 1ns / 1ps

module hcbf_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 32768
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                  i_wdata,
    input  logic                              i_re,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read; a read at the written address sees old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/hot_cold_bundle_filter_top.sv
`timescale 1ns / 1ps

// Channel  | Direction | Transfer when             | Payload
// s (in)   | slave     | i_s_tvalid & o_s_tready   | tdata: layer, neuron_index, grad_mag; tlast
// m (out)  | master    | o_m_tvalid & i_m_tready   | tdata: activity, batch, 3 counts; tuser; tlast
// cfg      | slave     | i_cfg_valid & o_cfg_ready | index, data
//
// One item per cycle while the output is not stalled; a result passes through stage 1 and
// then the output register before it is presented. The bundle store is one single-port-write
// RAM with registered read; the read-modify-write of an entry is forwarded from the output register.
// After reset the store is swept to zero across all LAYER_COUNT*BUNDLES_PER_LAYER entries
// (32768 by default), with o_s_tready low; configuration writes are taken throughout.
// A stalled output holds the stage behind it; outside the clearing sweep the input stalls
// only when both are full and the output is stalled.

module hot_cold_bundle_filter_top #(
    parameter int unsigned BUNDLE_SIZE       = 16,
    parameter int unsigned LAYER_COUNT       = 32,
    parameter int unsigned BUNDLES_PER_LAYER = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [39:0]  i_s_tdata,   // layer[4:0], neuron_index[18:5], grad_mag[34:19], zero
    input  logic         i_s_tlast,   // last_in_batch
    // result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [159:0] o_m_tdata,   // bundle_activity[23:0], batch_kept[39:24],
                                      // hot_hit_count[79:40], cold_fetch_count[119:80],
                                      // cold_drop_count[159:120]
    output logic [2:0]   o_m_tuser,   // keep[0], outcome[2:1]
    output logic         o_m_tlast,   // last_out
    // configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    localparam int unsigned DEPTH  = LAYER_COUNT * BUNDLES_PER_LAYER;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned ACT_W  = hcbf_pkg::ACT_W;
    localparam int unsigned CNT_W  = hcbf_pkg::CNT_W;
    localparam int unsigned BAT_W  = hcbf_pkg::BATCH_W;
    localparam int unsigned NIDX_W = hcbf_pkg::NIDX_W;

    // Configuration registers
    logic                             r_tier_en;
    logic [hcbf_pkg::HOTB_W-1:0]      r_hot_bundles;
    logic [hcbf_pkg::MAG_W-1:0]       r_cold_thr;

    // Clearing sweep
    logic                             r_clr_busy;
    logic [ADDR_W-1:0]                r_clr_addr;

    // Stage 1: store read in flight
    logic                             r_s1_valid;
    logic                             r_s1_hit;
    logic [ADDR_W-1:0]                r_s1_addr;
    logic [hcbf_pkg::GAIN_W-1:0]      r_s1_gain;
    hcbf_pkg::t_outcome               r_s1_outcome;
    logic                             r_s1_last;

    // Stage 2: output register
    logic                             r_s2_valid;
    logic                             r_s2_wr;
    logic [ADDR_W-1:0]                r_s2_addr;
    logic [ACT_W-1:0]                 r_s2_act;
    logic [BAT_W-1:0]                 r_s2_batch;
    hcbf_pkg::t_outcome               r_s2_outcome;
    logic                             r_s2_last;

    // Running totals
    logic [CNT_W-1:0]                 r_hot_total;
    logic [CNT_W-1:0]                 r_fetch_total;
    logic [CNT_W-1:0]                 r_drop_total;
    logic [BAT_W-1:0]                 r_batch;

    logic [hcbf_pkg::LAYER_W-1:0]     in_layer;
    logic [NIDX_W-1:0]                in_nidx;
    logic [hcbf_pkg::MAG_W-1:0]       in_mag;
    logic [NIDX_W-1:0]                in_bundle;
    logic                             in_range;
    logic [ADDR_W-1:0]                in_addr;
    logic                             in_accept;
    logic                             s1_adv;
    hcbf_pkg::t_outcome               in_outcome;
    logic [ACT_W-1:0]                 rd_data;
    logic [ACT_W-1:0]                 s1_old;
    logic [hcbf_pkg::SUM_W-1:0]       s1_sum;
    logic [ACT_W:0]                   s1_shifted;
    logic [ACT_W-1:0]                 s1_new;
    logic [BAT_W-1:0]                 s1_batch;
    logic                             ram_we;
    logic [ADDR_W-1:0]                ram_waddr;
    logic [ACT_W-1:0]                 ram_wdata;

    // Input unpacking
    assign in_layer  = i_s_tdata[4:0];
    assign in_nidx   = i_s_tdata[18:5];
    assign in_mag    = i_s_tdata[34:19];
    assign in_bundle = NIDX_W'(in_nidx / BUNDLE_SIZE);
    assign in_range  = (32'(in_layer) < LAYER_COUNT) && (32'(in_bundle) < BUNDLES_PER_LAYER);
    assign in_addr   = ADDR_W'(32'(in_layer) * BUNDLES_PER_LAYER + 32'(in_bundle));

    // Handshake
    assign s1_adv     = r_s1_valid && (!r_s2_valid || i_m_tready);
    assign o_s_tready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // Classification, settled at the input transfer
    always_comb begin
        if (!r_tier_en || (NIDX_W'(r_hot_bundles) > in_bundle)) begin
            in_outcome = hcbf_pkg::OUT_HOT_HIT;
        end else if (in_mag > r_cold_thr) begin
            in_outcome = hcbf_pkg::OUT_COLD_FETCH;
        end else begin
            in_outcome = hcbf_pkg::OUT_COLD_DROP;
        end
    end

    // Activity average: old value forwarded from the output stage on an address match
    assign s1_old     = (r_s2_valid && r_s2_wr && (r_s2_addr == r_s1_addr)) ? r_s2_act : rd_data;
    assign s1_sum     = hcbf_pkg::SUM_W'(s1_old) * hcbf_pkg::SUM_W'(hcbf_pkg::DECAY_Q16)
                      + hcbf_pkg::SUM_W'(r_s1_gain);
    assign s1_shifted = s1_sum[hcbf_pkg::SUM_W-1:16];
    assign s1_new     = s1_shifted[ACT_W] ? hcbf_pkg::ACT_MAX : s1_shifted[ACT_W-1:0];

    assign s1_batch = (r_s1_outcome != hcbf_pkg::OUT_COLD_DROP)
                    ? hcbf_pkg::inc_batch(r_batch) : r_batch;

    // Store write port: clearing sweep, else write-back
    assign ram_we    = r_clr_busy || (s1_adv && r_s1_hit);
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign ram_wdata = r_clr_busy ? '0 : s1_new;

    hcbf_ram #(
        .WIDTH (ACT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (in_addr),
        .o_rdata (rd_data)
    );

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tier_en     <= 1'b0;
            r_hot_bundles <= hcbf_pkg::HOTB_RESET;
            r_cold_thr    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hcbf_pkg::CFG_TIER_ENABLED:   r_tier_en     <= i_cfg_data[0];
                hcbf_pkg::CFG_HOT_BUNDLES:    r_hot_bundles <= i_cfg_data[hcbf_pkg::HOTB_W-1:0];
                hcbf_pkg::CFG_COLD_THRESHOLD: r_cold_thr    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
        if (in_accept) begin
            r_s1_hit     <= r_tier_en && in_range;
            r_s1_addr    <= in_addr;
            r_s1_gain    <= hcbf_pkg::GAIN_W'({in_mag, 8'd0})
                          * hcbf_pkg::GAIN_W'(hcbf_pkg::GAIN_Q16);
            r_s1_outcome <= in_outcome;
            r_s1_last    <= i_s_tlast;
        end
    end

    // Stage 2 and running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid    <= 1'b0;
            r_s2_wr       <= 1'b0;
            r_hot_total   <= '0;
            r_fetch_total <= '0;
            r_drop_total  <= '0;
            r_batch       <= '0;
        end else begin
            if (s1_adv) begin
                r_s2_valid <= 1'b1;
                r_s2_wr    <= r_s1_hit;
                r_batch    <= r_s1_last ? '0 : s1_batch;
                unique case (r_s1_outcome)
                    hcbf_pkg::OUT_HOT_HIT:    r_hot_total   <= hcbf_pkg::inc_cnt(r_hot_total);
                    hcbf_pkg::OUT_COLD_FETCH: r_fetch_total <= hcbf_pkg::inc_cnt(r_fetch_total);
                    hcbf_pkg::OUT_COLD_DROP:  r_drop_total  <= hcbf_pkg::inc_cnt(r_drop_total);
                    default: ;
                endcase
            end else if (i_m_tready) begin
                r_s2_valid <= 1'b0;
            end
        end
        if (s1_adv) begin
            r_s2_addr    <= r_s1_addr;
            r_s2_act     <= r_s1_hit ? s1_new : '0;
            r_s2_batch   <= s1_batch;
            r_s2_outcome <= r_s1_outcome;
            r_s2_last    <= r_s1_last;
        end
    end

    // Totals only move when a result enters the output register, so they are its counts
    assign o_m_tvalid = r_s2_valid;
    assign o_m_tdata  = {r_drop_total, r_fetch_total, r_hot_total, r_s2_batch, r_s2_act};
    assign o_m_tuser  = {r_s2_outcome, (r_s2_outcome != hcbf_pkg::OUT_COLD_DROP)};
    assign o_m_tlast  = r_s2_last;

    // No input transfer during the clearing sweep
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !in_accept)
        else $error("input transfer during store clear");

    // A result whose store entry was not touched carries zero activity
    a_untouched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !r_s2_wr) |-> (r_s2_act == '0))
        else $error("activity reported without store access");

    // Store write-back only happens when the item moves to the output register
    a_wb_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_clr_busy && ram_we) |=> (r_s2_valid && r_s2_wr))
        else $error("write-back without matching output");

    // Totals never fall
    a_totals_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_hot_total >= $past(r_hot_total))
                        && (r_fetch_total >= $past(r_fetch_total))
                        && (r_drop_total >= $past(r_drop_total)))
        else $error("running total decreased");

    // A stalled result does not let a new one into the output register
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !i_m_tready) |=> $stable(r_hot_total) && $stable(r_s2_batch))
        else $error("output register changed while stalled");

endmodule
